>>> rtl/mlrq_pkg.sv
// ----------------------------------------------------------------------------
// mlrq_pkg
// Shared types and constants of the multilevel ready queue.
// ----------------------------------------------------------------------------
package mlrq_pkg;

  localparam int unsigned LevelsDef     = 16;
  localparam int unsigned LevelDepthDef = 16;
  localparam int unsigned IdW           = 8;
  localparam int unsigned PrioW         = 4;
  localparam int unsigned QuantW        = 12;
  localparam int unsigned CfgW          = 8;
  localparam int unsigned CfgIdxW       = 1;
  localparam logic [QuantW-1:0] QuantMax = 12'hFFF;
  localparam logic [CfgW-1:0] QuantFirstRst = 8'd1;
  localparam logic [CfgW-1:0] QuantStepRst  = 8'd10;

  typedef enum logic [1:0] {
    KIND_ENQ    = 2'd0,
    KIND_DEQ    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_PEEK   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_QUANT_FIRST = 1'd0,
    REG_QUANT_STEP  = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IdW-1:0]   process_id;
    logic [PrioW-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IdW-1:0]    result_id;
    logic [QuantW-1:0] next_quantum;
    logic              all_empty;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;   // capture request
    logic start_op;   // begin operation step
    logic scan_step;  // advance removal scan
    logic finish;     // build result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic simple_done;
    logic scan_done;
  } dp_sts_t;

endpackage

>>> rtl/mlrq_if.sv
// ----------------------------------------------------------------------------
// mlrq_req_if / mlrq_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface mlrq_req_if;
  logic            valid;
  logic            ready;
  mlrq_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mlrq_rsp_if;
  logic            valid;
  logic            ready;
  mlrq_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/mlrq_ram.sv
// ----------------------------------------------------------------------------
// mlrq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mlrq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/mlrq_datapath.sv
// ----------------------------------------------------------------------------
// mlrq_datapath
// Per-level head/count registers, id store, removal scan and quantum.
// ----------------------------------------------------------------------------
module mlrq_datapath #(
  parameter int unsigned Levels     = mlrq_pkg::LevelsDef,
  parameter int unsigned LevelDepth = mlrq_pkg::LevelDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mlrq_pkg::dp_cmd_t               cmd_i,
  output mlrq_pkg::dp_sts_t               sts_o,
  input  mlrq_pkg::req_t                  req_i,
  input  logic [mlrq_pkg::CfgW-1:0]       quant_first_i,
  input  logic [mlrq_pkg::CfgW-1:0]       quant_step_i,
  output mlrq_pkg::rsp_t                  rsp_o
);
  import mlrq_pkg::*;

  localparam int unsigned LvlW  = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int unsigned PosW  = $clog2(LevelDepth);
  localparam int unsigned CntW  = $clog2(LevelDepth + 1);
  localparam int unsigned AddrW = $clog2(Levels * LevelDepth);
  localparam int unsigned LvlCW = $clog2(Levels + 1);

  logic [PosW-1:0] head_q [Levels];
  logic [CntW-1:0] count_q [Levels];

  req_t             req_q;
  logic [1:0]       status_q;
  logic [IdW-1:0]   rid_q;
  rsp_t             rsp_q;

  // scan state
  logic [LvlCW-1:0] sc_lvl_q;    // level under scan
  logic [CntW-1:0]  sc_k_q;      // offset being read
  logic             sc_found_q;  // match found in this level, shifting
  logic             sc_any_q;
  logic             sc_rd_q;     // read issued last cycle
  logic [CntW-1:0]  sc_rdk_q;    // offset of data returning

  // first non-empty level (priority search)
  logic             ne_any;
  logic [LvlW-1:0]  ne_lvl;
  always_comb begin
    ne_any = 1'b0;
    ne_lvl = '0;
    for (int i = Levels - 1; i >= 0; i--) begin
      if (count_q[i] != '0) begin
        ne_any = 1'b1;
        ne_lvl = LvlW'(i);
      end
    end
  end

  function automatic logic [PosW-1:0] wrap(input logic [PosW-1:0] h,
                                           input logic [CntW-1:0] off);
    logic [CntW:0] s;
    s = {1'b0, (CntW)'(h)} + {1'b0, off};
    if (s >= (CntW+1)'(LevelDepth)) s = s - (CntW+1)'(LevelDepth);
    return s[PosW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] addr_of(input logic [LvlW-1:0] l,
                                               input logic [PosW-1:0] p);
    return AddrW'(l) * AddrW'(LevelDepth) + AddrW'(p);
  endfunction

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [IdW-1:0]   ram_wdata, ram_rdata;

  mlrq_ram #(.Width(IdW), .Depth(Levels * LevelDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [LvlW-1:0] sc_l;
  logic [LvlW-1:0] enq_l;
  logic            enq_ok;
  logic [CntW-1:0] sc_n;
  logic            sc_lvl_end;
  logic            last_lvl;
  assign sc_l   = sc_lvl_q[LvlW-1:0];
  assign enq_l  = LvlW'(req_q.priority_req);
  assign enq_ok = (32'(req_q.priority_req) < Levels) && (count_q[enq_l] != CntW'(LevelDepth));
  assign sc_n   = count_q[sc_l];
  assign last_lvl = (sc_lvl_q == LvlCW'(Levels - 1));

  // a level ends once the data of its last offset returned (or it is empty)
  assign sc_lvl_end = (sc_n == '0) ||
                      (sc_rd_q && (sc_rdk_q == sc_n - CntW'(1)));

  assign sts_o.simple_done = 1'b1;
  assign sts_o.scan_done   = sc_lvl_end && last_lvl;

  // memory access
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_of(enq_l, wrap(head_q[enq_l], count_q[enq_l]));
    ram_wdata = req_q.process_id;
    ram_raddr = addr_of(ne_lvl, head_q[ne_lvl]);
    if (cmd_i.start_op && req_q.kind == KIND_ENQ && enq_ok) begin
      ram_we = 1'b1;
    end
    if (cmd_i.scan_step) begin
      ram_raddr = addr_of(sc_l, wrap(head_q[sc_l], sc_k_q));
      // shifting: slot k-1 takes data from slot k
      if (sc_found_q && sc_rd_q) begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(sc_l, wrap(head_q[sc_l], sc_rdk_q - CntW'(1)));
        ram_wdata = ram_rdata;
      end
    end
  end

  // quantum of first non-empty level
  logic [LvlW+CfgW-1:0] qprod;
  logic [QuantW-1:0]    quant;
  assign qprod = (LvlW+CfgW)'(ne_lvl) * (LvlW+CfgW)'(quant_step_i);
  always_comb begin
    if (!ne_any)             quant = '0;
    else if (ne_lvl == '0)   quant = QuantW'(quant_first_i);
    else if ((LvlW+CfgW) > QuantW && (qprod >> QuantW) != '0) quant = QuantMax;
    else                     quant = QuantW'(qprod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Levels; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
      sc_lvl_q   <= '0;
      sc_k_q     <= '0;
      sc_found_q <= 1'b0;
      sc_any_q   <= 1'b0;
      sc_rd_q    <= 1'b0;
      sc_rdk_q   <= '0;
      status_q   <= ST_OK;
      rid_q      <= '0;
    end else begin
      if (cmd_i.load_req) begin
        sc_lvl_q   <= '0;
        sc_k_q     <= '0;
        sc_found_q <= 1'b0;
        sc_any_q   <= 1'b0;
        sc_rd_q    <= 1'b0;
      end
      if (cmd_i.start_op) begin
        status_q <= ST_OK;
        rid_q    <= '0;
        unique case (kind_e'(req_q.kind))
          KIND_ENQ: begin
            if (enq_ok) count_q[enq_l] <= count_q[enq_l] + CntW'(1);
            else        status_q <= ST_FULL;
          end
          KIND_DEQ, KIND_PEEK: begin
            // head read was issued in the read state; data is captured here and used at finish
            if (!ne_any) status_q <= ST_EMPTY;
            else if (req_q.kind == KIND_DEQ) begin
              head_q[ne_lvl]  <= wrap(head_q[ne_lvl], CntW'(1));
              count_q[ne_lvl] <= count_q[ne_lvl] - CntW'(1);
            end
          end
          KIND_REMOVE: ;
          default: ;
        endcase
      end
      if (cmd_i.scan_step) begin
        if (sc_lvl_end) begin
          if (sc_found_q || (sc_rd_q && ram_rdata == req_q.process_id && sc_n != '0)) begin
            count_q[sc_l] <= sc_n - CntW'(1);
            sc_any_q <= 1'b1;
          end
          sc_lvl_q   <= sc_lvl_q + LvlCW'(1);
          sc_k_q     <= '0;
          sc_found_q <= 1'b0;
          sc_rd_q    <= 1'b0;
        end else begin
          if (sc_rd_q && !sc_found_q && ram_rdata == req_q.process_id) begin
            sc_found_q <= 1'b1;
          end
          if (sc_k_q < sc_n) begin
            sc_rd_q  <= 1'b1;
            sc_rdk_q <= sc_k_q;
            sc_k_q   <= sc_k_q + CntW'(1);
          end else begin
            sc_rd_q  <= 1'b0;
          end
        end
      end
      if (cmd_i.finish && req_q.kind == KIND_REMOVE) begin
        status_q <= sc_any_q ? ST_OK : ST_EMPTY;
        rid_q    <= sc_any_q ? req_q.process_id : '0;
      end
    end
  end

  // request capture and result build
  logic peek_vld_q;
  logic [IdW-1:0] head_id_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    // head id read issued in the read state via ram_raddr default
    if (cmd_i.start_op) begin
      head_id_q  <= ram_rdata;
      peek_vld_q <= ne_any && (req_q.kind == KIND_DEQ || req_q.kind == KIND_PEEK);
    end
    if (cmd_i.finish) begin
      rsp_q.next_quantum <= quant;
      rsp_q.all_empty    <= !ne_any;
      if (req_q.kind == KIND_REMOVE) begin
        rsp_q.status    <= sc_any_q ? ST_OK : ST_EMPTY;
        rsp_q.result_id <= sc_any_q ? req_q.process_id : '0;
      end else begin
        rsp_q.status    <= status_q;
        rsp_q.result_id <= peek_vld_q ? head_id_q : rid_q;
      end
    end
  end
  assign rsp_o = rsp_q;

endmodule

>>> rtl/mlrq_ctrl.sv
// ----------------------------------------------------------------------------
// mlrq_ctrl
// Sequencer: capture, read head, operate, scan for removal, respond.
// ----------------------------------------------------------------------------
module mlrq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mlrq_pkg::dp_cmd_t cmd_o,
  input  mlrq_pkg::dp_sts_t sts_i
);
  import mlrq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_OP    = 6'b000100,
    S_SCAN  = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   is_rem_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load_req = 1'b1;
        state_d = S_READ;
      end
      S_READ: state_d = S_OP;   // head read in flight
      S_OP: begin
        cmd_o.start_op = 1'b1;
        state_d = is_rem_q ? S_SCAN : S_FIN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        if (sts_i.simple_done) state_d = S_OUT;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      is_rem_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_req) is_rem_q <= (kind_i == KIND_REMOVE);
    end
  end
endmodule

>>> rtl/multilevel_ready_queue_core.sv
// ----------------------------------------------------------------------------
// multilevel_ready_queue_core
// Priority ready queue, one FIFO of ids per level, level 0 first.
// ----------------------------------------------------------------------------
// Usage: requests (kind, process_id, priority_req) arrive on req with a
// valid/ready handshake; one result (status, result_id, next_quantum,
// all_empty) leaves on rsp per request. One item is in work at a time.
// Enqueue, dequeue and peek pass through the read, operate and finish
// states from accept to result valid; the block returns to idle only
// once the result is taken, so a new request waits for it. Remove walks
// every level through the single id RAM read port, one entry a cycle,
// with one more scan step at the end of each level.
// The quantum registers are written through cfg_we_i / cfg_idx_i / cfg_data_i;
// the user must do so only while the block is idle; the block does not enforce it.
// Reset empties all levels and restores the quantum defaults; the id RAM
// itself is not cleared. A stalled result holds on rsp and no new request
// is accepted until it is taken.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_core #(
  parameter int unsigned Levels     = mlrq_pkg::LevelsDef,
  parameter int unsigned LevelDepth = mlrq_pkg::LevelDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mlrq_req_if.sink                      req,
  mlrq_rsp_if.source                    rsp,
  input  logic                          cfg_we_i,
  input  logic [mlrq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mlrq_pkg::CfgW-1:0]     cfg_data_i
);
  import mlrq_pkg::*;

  logic [CfgW-1:0] quant_first_q, quant_step_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_first_q <= QuantFirstRst;
      quant_step_q  <= QuantStepRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_QUANT_FIRST: quant_first_q <= cfg_data_i;
        REG_QUANT_STEP:  quant_step_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mlrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .kind_i      (req.data.kind),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mlrq_datapath #(.Levels(Levels), .LevelDepth(LevelDepth)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_i         (req.data),
    .quant_first_i (quant_first_q),
    .quant_step_i  (quant_step_q),
    .rsp_o         (rsp.data)
  );
endmodule

>>> test/tb_multilevel_ready_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multilevel_ready_queue_core
// Drives enqueue, dequeue, peek and remove requests into the ready queue,
// predicts each result with a behavioral queue model and checks every field.
// ----------------------------------------------------------------------------
module tb_multilevel_ready_queue_core;
  import mlrq_pkg::*;

  localparam int unsigned NLev   = LevelsDef;
  localparam int unsigned NDepth = LevelDepthDef;
  localparam int unsigned StallLimit = 5000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  mlrq_req_if req_ch ();
  mlrq_rsp_if rsp_ch ();

  multilevel_ready_queue_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req_ch.sink), .rsp(rsp_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // Behavioral queue: one id list per level, head first
  logic [IdW-1:0] lvl_ids[NLev][$];
  logic [CfgW-1:0] q_first, q_step;
  rsp_t pending_rsp[$];
  int unsigned fail_cnt;
  int unsigned idle_cycles;
  bit rsp_stall_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_v);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $time);
    fail_cnt++;
  endtask

  function automatic int first_busy_level();
    for (int i = 0; i < NLev; i++) if (lvl_ids[i].size() != 0) return i;
    return -1;
  endfunction

  function automatic logic [QuantW-1:0] quantum_for(int lvl);
    int unsigned q;
    if (lvl < 0) return '0;
    q = (lvl == 0) ? q_first : lvl * q_step;
    return (q > QuantMax) ? QuantMax : q[QuantW-1:0];
  endfunction

  function automatic rsp_t queue_step(req_t r);
    rsp_t o;
    int lvl;
    bit hit;
    o = '0;
    o.status = ST_OK;
    case (kind_e'(r.kind))
      KIND_ENQ: begin
        if (r.priority_req >= NLev || lvl_ids[r.priority_req].size() >= NDepth)
          o.status = ST_FULL;
        else lvl_ids[r.priority_req].push_back(r.process_id);
      end
      KIND_DEQ, KIND_PEEK: begin
        lvl = first_busy_level();
        if (lvl < 0) o.status = ST_EMPTY;
        else begin
          o.result_id = lvl_ids[lvl][0];
          if (r.kind == KIND_DEQ) void'(lvl_ids[lvl].pop_front());
        end
      end
      default: begin
        hit = 1'b0;
        for (int i = 0; i < NLev; i++)
          for (int k = 0; k < lvl_ids[i].size(); k++)
            if (lvl_ids[i][k] == r.process_id) begin
              lvl_ids[i].delete(k);
              hit = 1'b1;
              break;
            end
        if (hit) o.result_id = r.process_id;
        else o.status = ST_EMPTY;
      end
    endcase
    lvl = first_busy_level();
    o.next_quantum = quantum_for(lvl);
    o.all_empty = (lvl < 0);
    return o;
  endfunction

  function automatic int rand_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result sink: random stalls, checks against oldest expectation
  int unsigned rsp_gap;
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("unexpected result at %0t", $time);
        fail_cnt++;
      end else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        if (rsp_ch.data.status !== e.status)
          report_mismatch("status", int'(rsp_ch.data.status), int'(e.status));
        if (rsp_ch.data.result_id !== e.result_id)
          report_mismatch("result_id", int'(rsp_ch.data.result_id), int'(e.result_id));
        if (rsp_ch.data.next_quantum !== e.next_quantum)
          report_mismatch("next_quantum", int'(rsp_ch.data.next_quantum),
                          int'(e.next_quantum));
        if (rsp_ch.data.all_empty !== e.all_empty)
          report_mismatch("all_empty", int'(rsp_ch.data.all_empty), int'(e.all_empty));
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      rsp_gap = 0;
    end else if (!rsp_stall_on) begin
      rsp_ch.ready <= 1'b1;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (rsp_ch.ready) rsp_gap = rand_gap();
    end
  end

  // Watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_ni)
      idle_cycles = 0;
    else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input req_t r);
    int gap;
    gap = rsp_stall_on ? rand_gap() : 0;
    // always move to a fresh falling edge so valid never gets two updates at once
    repeat (gap + 1) @(negedge clk_i);
    req_ch.data <= r;
    req_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
    pending_rsp.push_back(queue_step(r));
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_QUANT_FIRST) q_first = val; else q_step = val;
  endtask

  function automatic req_t mk(kind_e k, int id, int pr);
    req_t r;
    r.kind = k;
    r.process_id = id[IdW-1:0];
    r.priority_req = pr[PrioW-1:0];
    return r;
  endfunction

  // Directed rows; typed-in expectation checked only where marked
  typedef struct {
    req_t r;
    bit   has_exp;
    rsp_t exp_rsp;
  } dir_row_t;

  function automatic req_t rand_item();
    int unsigned p;
    int lvl;
    int unsigned lo, hi;
    p = $urandom_range(0, 99);
    // Bias levels toward a few, sometimes low, to reach full levels
    lvl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    lo = $urandom_range(0, 1) ? 0 : 200;
    hi = lo + 55;
    if (p < 45) return mk(KIND_ENQ, $urandom_range(lo, hi), lvl);
    if (p < 70) return mk(KIND_DEQ, $urandom_range(0, 255), $urandom_range(0, 15));
    if (p < 80) return mk(KIND_PEEK, $urandom_range(0, 255), $urandom_range(0, 15));
    return mk(KIND_REMOVE, $urandom_range(lo, hi), $urandom_range(0, 15));
  endfunction

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    rsp_t got_exp;
    fail_cnt = 0;
    idle_cycles = 0;
    rsp_stall_on = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_QUANT_FIRST;
    cfg_data_i = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    q_first = QuantFirstRst;
    q_step = QuantStepRst;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    row.has_exp = 1'b1;
    row.r = mk(KIND_DEQ, 0, 0);   row.exp_rsp = '{ST_EMPTY, 8'd0, 12'd0, 1'b1};
    rows.push_back(row);
    row.r = mk(KIND_PEEK, 255, 15); row.exp_rsp = '{ST_EMPTY, 8'd0, 12'd0, 1'b1};
    rows.push_back(row);
    row.r = mk(KIND_REMOVE, 7, 0); row.exp_rsp = '{ST_EMPTY, 8'd0, 12'd0, 1'b1};
    rows.push_back(row);
    row.r = mk(KIND_ENQ, 255, 15); row.exp_rsp = '{ST_OK, 8'd0, 12'd150, 1'b0};
    rows.push_back(row);
    row.r = mk(KIND_ENQ, 0, 0);   row.exp_rsp = '{ST_OK, 8'd0, 12'd1, 1'b0};
    rows.push_back(row);
    row.has_exp = 1'b0;
    row.r = mk(KIND_ENQ, 0, 0);   rows.push_back(row); // duplicate id
    row.r = mk(KIND_ENQ, 0, 3);   rows.push_back(row);
    row.r = mk(KIND_PEEK, 0, 0);  rows.push_back(row);
    row.r = mk(KIND_REMOVE, 0, 0); rows.push_back(row);
    row.r = mk(KIND_DEQ, 0, 0);   rows.push_back(row);
    row.r = mk(KIND_DEQ, 0, 0);   rows.push_back(row);
    row.r = mk(KIND_DEQ, 0, 0);   rows.push_back(row);
    // fill level 5 then overflow it
    for (int i = 0; i < NDepth + 1; i++) begin
      row.r = mk(KIND_ENQ, 8'hA0 + i, 5);
      rows.push_back(row);
    end
    foreach (rows[i]) begin
      send_item(rows[i].r);
      if (rows[i].has_exp) begin
        got_exp = pending_rsp[$];
        if (got_exp != rows[i].exp_rsp) begin
          $display("directed row %0d disagrees with table", i);
          fail_cnt++;
        end
      end
    end
    drain();

    // Saturation extremes, then zero, random and saturated values again
    write_reg(REG_QUANT_FIRST, 8'd255);
    write_reg(REG_QUANT_STEP, 8'd255);
    send_item(mk(KIND_ENQ, 9, 0));
    send_item(mk(KIND_DEQ, 0, 0));
    drain();
    write_reg(REG_QUANT_STEP, 8'd0);
    write_reg(REG_QUANT_FIRST, 8'd0);
    rsp_stall_on = 1'b1;
    for (int n = 0; n < 150; n++) send_item(rand_item());
    drain();
    write_reg(REG_QUANT_FIRST, 8'($urandom_range(0, 255)));
    write_reg(REG_QUANT_STEP, 8'($urandom_range(0, 255)));
    for (int n = 0; n < 150; n++) send_item(rand_item());
    drain();
    write_reg(REG_QUANT_FIRST, 8'd255);
    write_reg(REG_QUANT_STEP, 8'd255);
    for (int n = 0; n < 150; n++) send_item(rand_item());
    drain();

    if (fail_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
